// ----- sv/pixel_curve_lut_blend_defines.svh -----
// assertion macros for the tone-curve block
`ifndef PIXEL_CURVE_LUT_BLEND_DEFINES_SVH
`define PIXEL_CURVE_LUT_BLEND_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PLCB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_curve_lut_blend: assertion failed");

// next-cycle implication
`define PLCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_curve_lut_blend: assertion failed");

`else

`define PLCB_ASSERT_NOW(label, clk, rst, ante, cons)
`define PLCB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/plcb_pkg.sv -----
`default_nettype none

package plcb_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int TABLE_DEPTH = 256;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] TABLE_BLUE   = 2'd0;
   localparam logic [1:0] TABLE_GREEN  = 2'd1;
   localparam logic [1:0] TABLE_RED    = 2'd2;
   localparam logic [1:0] TABLE_MASTER = 2'd3;

   localparam logic [SAMPLE_W-1:0] MASK_FULL = 8'd255;

   // control shared by the three colour lanes
   typedef struct packed {
      logic advance;
      logic master_we;
      logic use_mask;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ----- sv/pixel_curve_lut_blend.sv -----
`default_nettype none

// Tone-curve lookup for BGR pixels with optional mask blend. A transaction on
// the req_ channel is either a pixel (cmd 0) or a write of one table entry
// (cmd 1: table_select 0 blue, 1 green, 2 red, 3 master). A pixel looks up
// each colour in its own table and the result again in the master table;
// with use_mask set, the curve is blended with the input sample as
// floor((curve*m + in*(255-m))/255). extra_in is copied through. One
// transaction is taken every clock unless req_stall is high. A pixel's
// channel table is read at the accepting edge, then come the master
// table read, the blend multiply and the divide by 255 into the output
// register that drives rsp_. Table writes give no result and stay in
// order with pixels, so a pixel straight after a write sees the new entry.
// Tables are not cleared by reset and must be loaded before use.
// csr_use_mask may only be written while the block is idle; csr_ready is
// always high.
module pixel_curve_lut_blend (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_blue_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_extra_in,
   input  wire logic [7:0] req_mask_level,
   input  wire logic [1:0] req_table_select,
   input  wire logic [7:0] req_table_index,
   input  wire logic [7:0] req_table_value,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_blue_out,
   output logic      [7:0] rsp_green_out,
   output logic      [7:0] rsp_red_out,
   output logic      [7:0] rsp_extra_out,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_use_mask
);

`include "pixel_curve_lut_blend_defines.svh"

   localparam int W = plcb_pkg::SAMPLE_W;

   // whole pipeline moves unless the output register is full and held
   logic advance;
   logic req_accept;
   logic chan_write;

   // configuration
   logic use_mask_ff;

   // stage 1: channel table read in flight, write fields kept for master
   logic         v1_ff;
   logic         cmd1_ff;
   logic [1:0]   sel1_ff;
   logic [W-1:0] index1_ff;
   logic [W-1:0] value1_ff;
   logic [W-1:0] mask1_ff;
   logic [W-1:0] extra1_ff;

   // stage 2: master table read, pixels only from here on
   logic         v2_ff;
   logic [W-1:0] mask2_ff;
   logic [W-1:0] extra2_ff;

   // stage 3: blend products
   logic         v3_ff;
   logic [W-1:0] extra3_ff;

   // output register
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_blue_ff;
   logic [W-1:0] rsp_green_ff;
   logic [W-1:0] rsp_red_ff;
   logic [W-1:0] rsp_extra_ff;

   logic [W-1:0] blue_res;
   logic [W-1:0] green_res;
   logic [W-1:0] red_res;

   plcb_pkg::lane_ctl_type lane_ctl;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;
   assign chan_write = req_accept && (req_cmd == plcb_pkg::CMD_WRITE);
   assign csr_ready  = 1'b1;

   // master writes happen in stage 2, in step with master reads
   assign lane_ctl.advance   = advance;
   assign lane_ctl.master_we = advance && v1_ff && (cmd1_ff == plcb_pkg::CMD_WRITE)
                               && (sel1_ff == plcb_pkg::TABLE_MASTER);
   assign lane_ctl.use_mask  = use_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_mask_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         use_mask_ff <= csr_use_mask;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff && (cmd1_ff == plcb_pkg::CMD_PIXEL);
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff      <= req_cmd;
         sel1_ff      <= req_table_select;
         index1_ff    <= req_table_index;
         value1_ff    <= req_table_value;
         mask1_ff     <= req_mask_level;
         extra1_ff    <= req_extra_in;
         mask2_ff     <= mask1_ff;
         extra2_ff    <= extra1_ff;
         extra3_ff    <= extra2_ff;
         rsp_blue_ff  <= blue_res;
         rsp_green_ff <= green_res;
         rsp_red_ff   <= red_res;
         rsp_extra_ff <= extra3_ff;
      end
   end

   plcb_lane u_blue (
      .clock           (clock),
      .ctl             (lane_ctl),
      .chan_we         (chan_write && (req_table_select == plcb_pkg::TABLE_BLUE)),
      .chan_wr_index   (req_table_index),
      .chan_wr_value   (req_table_value),
      .master_wr_index (index1_ff),
      .master_wr_value (value1_ff),
      .sample_in       (req_blue_in),
      .mask_s2         (mask2_ff),
      .result          (blue_res)
   );

   plcb_lane u_green (
      .clock           (clock),
      .ctl             (lane_ctl),
      .chan_we         (chan_write && (req_table_select == plcb_pkg::TABLE_GREEN)),
      .chan_wr_index   (req_table_index),
      .chan_wr_value   (req_table_value),
      .master_wr_index (index1_ff),
      .master_wr_value (value1_ff),
      .sample_in       (req_green_in),
      .mask_s2         (mask2_ff),
      .result          (green_res)
   );

   plcb_lane u_red (
      .clock           (clock),
      .ctl             (lane_ctl),
      .chan_we         (chan_write && (req_table_select == plcb_pkg::TABLE_RED)),
      .chan_wr_index   (req_table_index),
      .chan_wr_value   (req_table_value),
      .master_wr_index (index1_ff),
      .master_wr_value (value1_ff),
      .sample_in       (req_red_in),
      .mask_s2         (mask2_ff),
      .result          (red_res)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_extra_out = rsp_extra_ff;

   // an accepted pixel enters stage 1 as a pixel
   `PLCB_ASSERT_NEXT(a_pixel_enters, clock, reset,
      req_accept && (req_cmd == plcb_pkg::CMD_PIXEL),
      v1_ff && (cmd1_ff == plcb_pkg::CMD_PIXEL))

   // a table write never turns into a result
   `PLCB_ASSERT_NEXT(a_write_no_result, clock, reset,
      advance && v1_ff && (cmd1_ff == plcb_pkg::CMD_WRITE), !v2_ff)

   // a held pipeline keeps its stage 3 and output valid bits
   `PLCB_ASSERT_NEXT(a_stall_holds, clock, reset,
      !advance, $stable(v3_ff) && $stable(rsp_valid_ff))

   // master writes only come from stage 1 write transactions
   `PLCB_ASSERT_NOW(a_master_we_src, clock, reset,
      lane_ctl.master_we, v1_ff && (cmd1_ff == plcb_pkg::CMD_WRITE))

endmodule

`default_nettype wire

// ----- sv/plcb_ram.sv -----
`default_nettype none

module plcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/plcb_lane.sv -----
`default_nettype none

// one colour channel: channel table, master table copy, blend and /255
module plcb_lane (
   input  wire logic                           clock,
   input  wire plcb_pkg::lane_ctl_type         ctl,
   input  wire logic                           chan_we,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  chan_wr_index,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  chan_wr_value,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  master_wr_index,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  master_wr_value,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  sample_in,
   input  wire logic [plcb_pkg::SAMPLE_W-1:0]  mask_s2,
   output logic      [plcb_pkg::SAMPLE_W-1:0]  result
);

   localparam int W = plcb_pkg::SAMPLE_W;

   logic [W-1:0]   chan_rd;
   logic [W-1:0]   curve_rd;
   logic [W-1:0]   sample1_ff;
   logic [W-1:0]   sample2_ff;
   logic [W-1:0]   curve3_ff;
   logic [2*W-1:0] blend3_ff;
   logic [2*W-1:0] blend3_in;
   logic [2*W:0]   div_sum;
   logic [W-1:0]   blended;

   plcb_ram #(.WIDTH(W), .DEPTH(plcb_pkg::TABLE_DEPTH)) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_we),
      .wr_addr (chan_wr_index),
      .wr_data (chan_wr_value),
      .rd_en   (ctl.advance),
      .rd_addr (sample_in),
      .rd_data (chan_rd)
   );

   plcb_ram #(.WIDTH(W), .DEPTH(plcb_pkg::TABLE_DEPTH)) u_master_ram (
      .clock   (clock),
      .wr_en   (ctl.master_we),
      .wr_addr (master_wr_index),
      .wr_data (master_wr_value),
      .rd_en   (ctl.advance),
      .rd_addr (chan_rd),
      .rd_data (curve_rd)
   );

   // curve*m + in*(255-m), at most 65025
   assign blend3_in = ({{W{1'b0}}, curve_rd} * {{W{1'b0}}, mask_s2})
                    + ({{W{1'b0}}, sample2_ff}
                       * {{W{1'b0}}, plcb_pkg::MASK_FULL - mask_s2});

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         sample1_ff <= sample_in;
         sample2_ff <= sample1_ff;
         curve3_ff  <= curve_rd;
         blend3_ff  <= blend3_in;
      end
   end

   // floor(x/255) = (x + (x>>8) + 1) >> 8 for x up to 65025
   assign div_sum = {1'b0, blend3_ff} + {{(W+1){1'b0}}, blend3_ff[2*W-1:W]}
                  + {{(2*W){1'b0}}, 1'b1};
   assign blended = div_sum[2*W-1:W];

   assign result = ctl.use_mask ? blended : curve3_ff;

endmodule

`default_nettype wire
